>>> sv/segment_circle_gather_test_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the gather test checker
// Concurrent assertion wrappers with and without reset qualification.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_CIRCLE_GATHER_TEST_MACROS_SVH
`define SEGMENT_CIRCLE_GATHER_TEST_MACROS_SVH

// Checked only outside reset.
`define SGT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, during reset too.
`define SGT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/sgt_pkg.sv
// ----------------------------------------------------------------------------
// sgt_pkg
// Stage layout and the per-stage word carried down the gather test pipeline.
// ----------------------------------------------------------------------------
package sgt_pkg;

  localparam int unsigned NumStg   = 17;
  localparam int unsigned StDiff   = 0;
  localparam int unsigned StProd   = 1;
  localparam int unsigned StSum    = 2;
  localparam int unsigned StPrep   = 3;
  localparam int unsigned DivFirst = 4;
  localparam int unsigned DivLast  = 11;
  localparam int unsigned StTq     = 12;
  localparam int unsigned StOff    = 13;
  localparam int unsigned StPart   = 14;
  localparam int unsigned StSq     = 15;
  localparam int unsigned StOut    = 16;

  localparam logic [16:0] TqOne = 17'h10000;

  typedef struct packed {
    logic [NumStg-1:0] en;
    logic [NumStg-1:0] vld;
  } flow_t;

  typedef struct packed {
    logic signed [32:0]  dx;
    logic signed [32:0]  dy;
    logic signed [32:0]  ux;
    logic signed [32:0]  uy;
    logic [32:0]         s;
    logic                degen;
    logic                neg;
    logic                one;
    logic                inr;
    logic [65:0]         dd_x;
    logic [65:0]         dd_y;
    logic signed [65:0]  du_x;
    logic signed [65:0]  du_y;
    logic [65:0]         ss;
    logic [65:0]         len2;
    logic signed [66:0]  dot;
    logic [65:0]         m;
    logic [48:0]         ltl;
    logic [48:0]         lth;
    logic [65:0]         rem;
    logic [15:0]         q;
    logic [101:0]        limit;
    logic [16:0]         tq;
    logic signed [50:0]  tdx;
    logic signed [50:0]  tdy;
    logic [49:0]         mx;
    logic [49:0]         my;
    logic [49:0]         xhh;
    logic [49:0]         xhl;
    logic [49:0]         xll;
    logic [49:0]         yhh;
    logic [49:0]         yhl;
    logic [49:0]         yll;
    logic [101:0]        x2;
    logic [101:0]        y2;
    logic                gathered;
    logic [62:0]         sqd;
    logic [15:0]         item_id;
    logic [15:0]         mover_id;
  } pl_t;

endpackage

>>> sv/sgt_if.sv
// ----------------------------------------------------------------------------
// sgt_in_if / sgt_out_if
// Valid/ready channels for pair words and result words.
// ----------------------------------------------------------------------------
interface sgt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic [31:0]        mover_width;
  logic signed [31:0] item_x;
  logic signed [31:0] item_y;
  logic [31:0]        item_width;
  logic [15:0]        item_id;
  logic [15:0]        mover_id;

  modport source (output valid, start_x, start_y, end_x, end_y, mover_width,
                  item_x, item_y, item_width, item_id, mover_id, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, mover_width,
                  item_x, item_y, item_width, item_id, mover_id, output ready);
endinterface

interface sgt_out_if;
  logic        valid;
  logic        ready;
  logic        gathered;
  logic        degenerate;
  logic [16:0] hit_time;
  logic [62:0] dist_sq;
  logic [15:0] out_item_id;
  logic [15:0] out_mover_id;

  modport source (output valid, gathered, degenerate, hit_time, dist_sq,
                  out_item_id, out_mover_id, input ready);
  modport sink   (input valid, gathered, degenerate, hit_time, dist_sq,
                  out_item_id, out_mover_id, output ready);
endinterface

>>> sv/segment_circle_gather_test.sv
// Each accepted pair word moves through the stage registers from StDiff to StOut in order.
// Throughput: one pair word per cycle when not stalled; each stage holds one word and a stall
// at the output backs up stage by stage while empty stages keep filling.
// The 16-bit projection quotient takes eight stages, two bits per stage.
// Reset clears all valid bits and sets the tolerance register to zero.
// ----------------------------------------------------------------------------
// segment_circle_gather_test
// Projects an item onto a move segment and tests reach against both radii.
// ----------------------------------------------------------------------------
module segment_circle_gather_test (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  sgt_in_if.sink       in_i,
  sgt_out_if.source    out_o
);
  import sgt_pkg::*;

  logic [15:0] tol_q;
  flow_t       flow;
  pl_t         p_q [NumStg];
  pl_t         p_d [NumStg];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  sgt_flow u_flow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .flow_o      (flow)
  );

  always_comb begin
    pl_t          p;
    logic [66:0]  dmag;
    logic [81:0]  lt;
    logic [82:0]  bound;
    logic [66:0]  r2;
    logic signed [50:0] wx, wy;
    logic [50:0]  ax, ay;
    logic [101:0] w2;

    lt    = '0;
    bound = '0;

    // Operand differences, width sum and degenerate flag.
    p = '0;
    p.dx = $signed({in_i.end_x[31], in_i.end_x}) - $signed({in_i.start_x[31], in_i.start_x});
    p.dy = $signed({in_i.end_y[31], in_i.end_y}) - $signed({in_i.start_y[31], in_i.start_y});
    p.ux = $signed({in_i.item_x[31], in_i.item_x}) - $signed({in_i.start_x[31], in_i.start_x});
    p.uy = $signed({in_i.item_y[31], in_i.item_y}) - $signed({in_i.start_y[31], in_i.start_y});
    p.s  = {1'b0, in_i.mover_width} + {1'b0, in_i.item_width};
    p.degen    = (p.dx == '0) && (p.dy == '0);
    p.item_id  = in_i.item_id;
    p.mover_id = in_i.mover_id;
    p_d[StDiff] = p;

    p = p_q[StDiff];
    p.dd_x = 66'(p.dx * p.dx);
    p.dd_y = 66'(p.dy * p.dy);
    p.du_x = 66'(p.ux * p.dx);
    p.du_y = 66'(p.uy * p.dy);
    p.ss   = 66'(p.s * p.s);
    p_d[StProd] = p;

    p = p_q[StProd];
    p.len2 = p.dd_x + p.dd_y;
    p.dot  = $signed({p.du_x[65], p.du_x}) + $signed({p.du_y[65], p.du_y});
    p_d[StSum] = p;

    p = p_q[StSum];
    p.neg = p.dot[66];
    dmag  = p.neg ? (~p.dot + 67'd1) : p.dot;
    p.m   = dmag[65:0];
    p.one = !p.neg && (p.len2 <= p.m);
    p.ltl = 49'(p.len2[32:0] * tol_q);
    p.lth = 49'(p.len2[65:33] * tol_q);
    p.rem = p.m;
    p.q   = '0;
    p.limit = ({36'b0, p.ss} << 30) + ({86'b0, tol_q} << 32);
    p_d[StPrep] = p;

    // Quotient stages: two restoring steps each. The first also settles the
    // range test, since len2 * tolerance is ready here.
    for (int i = DivFirst; i <= DivLast; i++) begin
      p = p_q[i-1];
      if (i == DivFirst) begin
        lt    = {p.lth, 33'b0} + {33'b0, p.ltl};
        bound = p.neg ? {1'b0, lt} : ({1'b0, p.len2, 16'b0} + {1'b0, lt});
        p.inr = {1'b0, p.m, 16'b0} <= bound;
      end
      for (int k = 0; k < 2; k++) begin
        r2 = {p.rem, 1'b0};
        if (r2 >= {1'b0, p.len2}) begin
          r2    = r2 - {1'b0, p.len2};
          p.q   = {p.q[14:0], 1'b1};
        end else begin
          p.q   = {p.q[14:0], 1'b0};
        end
        p.rem = r2[65:0];
      end
      p_d[i] = p;
    end

    p = p_q[DivLast];
    if (p.degen || p.neg) begin
      p.tq = '0;
    end else if (p.one) begin
      p.tq = TqOne;
    end else begin
      p.tq = {1'b0, p.q};
    end
    p.tdx = 51'($signed({1'b0, p.tq}) * p.dx);
    p.tdy = 51'($signed({1'b0, p.tq}) * p.dy);
    p_d[StTq] = p;

    // Offset from the nearest point in 2^-32 units.
    p  = p_q[StTq];
    wx = $signed({{2{p.ux[32]}}, p.ux, 16'b0}) - p.tdx;
    wy = $signed({{2{p.uy[32]}}, p.uy, 16'b0}) - p.tdy;
    ax = wx[50] ? (~wx + 51'd1) : wx;
    ay = wy[50] ? (~wy + 51'd1) : wy;
    p.mx = ax[49:0];
    p.my = ay[49:0];
    p_d[StOff] = p;

    p = p_q[StOff];
    p.xhh = 50'(p.mx[49:25] * p.mx[49:25]);
    p.xhl = 50'(p.mx[49:25] * p.mx[24:0]);
    p.xll = 50'(p.mx[24:0] * p.mx[24:0]);
    p.yhh = 50'(p.my[49:25] * p.my[49:25]);
    p.yhl = 50'(p.my[49:25] * p.my[24:0]);
    p.yll = 50'(p.my[24:0] * p.my[24:0]);
    p_d[StPart] = p;

    p = p_q[StPart];
    p.x2 = ({52'b0, p.xhh} << 50) + ({52'b0, p.xhl} << 26) + {52'b0, p.xll};
    p.y2 = ({52'b0, p.yhh} << 50) + ({52'b0, p.yhl} << 26) + {52'b0, p.yll};
    p_d[StSq] = p;

    p  = p_q[StSq];
    w2 = p.x2 + p.y2;
    p.gathered = !p.degen && p.inr && (w2 <= p.limit);
    p.sqd = (w2[101:95] != '0) ? '1 : w2[94:32];
    p_d[StOut] = p;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NumStg; i++) begin
      if (flow.en[i]) begin
        p_q[i] <= p_d[i];
      end
    end
  end

  assign in_i.ready         = flow.en[0];
  assign out_o.valid        = flow.vld[NumStg-1];
  assign out_o.gathered     = p_q[StOut].gathered;
  assign out_o.degenerate   = p_q[StOut].degen;
  assign out_o.hit_time     = p_q[StOut].tq;
  assign out_o.dist_sq      = p_q[StOut].sqd;
  assign out_o.out_item_id  = p_q[StOut].item_id;
  assign out_o.out_mover_id = p_q[StOut].mover_id;

endmodule

>>> sv/sgt_flow.sv
// ----------------------------------------------------------------------------
// sgt_flow
// Valid bits and per-stage load enables; a stage loads when it is empty or
// when the stage after it moves, so bubbles collapse under a stall.
// ----------------------------------------------------------------------------
module sgt_flow (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_ready_i,
  output sgt_pkg::flow_t flow_o
);
  import sgt_pkg::*;

  logic [NumStg-1:0] vld_q, vld_d, en;

  always_comb begin
    en[NumStg-1] = !vld_q[NumStg-1] || out_ready_i;
    for (int i = NumStg - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int i = 1; i < NumStg; i++) begin
      vld_d[i] = en[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign flow_o.en  = en;
  assign flow_o.vld = vld_q;

endmodule

>>> sv/sgt_check.sv
// ----------------------------------------------------------------------------
// sgt_check
// Port-level checks on result words, bound to the top level.
// ----------------------------------------------------------------------------
`include "segment_circle_gather_test_macros.svh"

module sgt_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic        gathered_i,
  input logic        degenerate_i,
  input logic [16:0] hit_time_i
);

  `SGT_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !valid_i, "valid during reset")
  `SGT_ASSERT(a_valid_hold, clk_i, rst_ni, valid_i && !ready_i |=> valid_i, "valid dropped")
  `SGT_ASSERT(a_degen_skip, clk_i, rst_ni, valid_i && degenerate_i |-> !gathered_i && (hit_time_i == 17'd0), "degenerate word gathered")
  `SGT_ASSERT(a_time_range, clk_i, rst_ni, valid_i |-> hit_time_i <= 17'h10000, "hit time above one")

endmodule

bind segment_circle_gather_test sgt_check u_sgt_check (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_i      (out_o.valid),
  .ready_i      (out_o.ready),
  .gathered_i   (out_o.gathered),
  .degenerate_i (out_o.degenerate),
  .hit_time_i   (out_o.hit_time)
);

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gather test pipeline testbench
// Streams pair words through the block and compares every result word with
// typed-in values or a bit-exact projection and reach predictor, over several
// tolerance settings and several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic [31:0]        mover_width;
    logic signed [31:0] item_x;
    logic signed [31:0] item_y;
    logic [31:0]        item_width;
    logic [15:0]        item_id;
    logic [15:0]        mover_id;
  } pair_t;

  typedef struct {
    logic        gathered;
    logic        degenerate;
    logic [16:0] hit_time;
    logic [62:0] dist_sq;
    logic [15:0] item_id;
    logic [15:0] mover_id;
  } reach_t;

  typedef struct {
    pair_t  pair;
    logic   typed;
    reach_t res;
  } vector_t;

  localparam int  HalfPeriod = 5;
  localparam int  CycleLimit = 200000;
  localparam int  DrainWait  = 30;
  localparam int  NumRandom  = 640;
  localparam logic signed [31:0] One = 32'sh0001_0000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  sgt_in_if  pair_if ();
  sgt_out_if reach_if ();

  segment_circle_gather_test uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (pair_if),
    .out_o      (reach_if)
  );

  always #HalfPeriod clk_i = ~clk_i;

  logic [15:0] tolerance = '0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  reach_t      expected_q[$];
  logic        cur_typed = 1'b0;
  reach_t      cur_res;
  logic        pair_taken = 1'b0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          gathers_seen = 0;
  int          degens_seen = 0;
  int          cycles = 0;

  // Exact projection, clamp, distance and reach test at full width.
  function automatic reach_t predict_reach(pair_t p, logic [15:0] tol);
    longint sx, sy, dx, dy, ux, uy, wx, wy, tq;
    logic signed [127:0] tl, sdx, sdy, sux, suy, len2, dot, w2, sw, lim, sx2;
    reach_t r;
    sx = longint'(p.start_x);
    sy = longint'(p.start_y);
    dx = longint'(p.end_x) - sx;
    dy = longint'(p.end_y) - sy;
    ux = longint'(p.item_x) - sx;
    uy = longint'(p.item_y) - sy;
    sdx = dx; sdy = dy; sux = ux; suy = uy;
    tl = {112'b0, tol};
    sw = {95'b0, ({1'b0, p.mover_width} + {1'b0, p.item_width})};
    tq = 0;
    r.degenerate = (dx == 0 && dy == 0);
    r.gathered = 1'b0;
    if (!r.degenerate) begin
      len2 = sdx * sdx + sdy * sdy;
      dot = sux * sdx + suy * sdy;
      if (dot < 0) begin
        r.gathered = ((-dot) <<< 16) <= len2 * tl;
      end else begin
        r.gathered = (dot <<< 16) <= len2 * (tl + 128'sd65536);
        if (len2 <= dot) tq = 65536;
        else begin
          sx2 = (dot <<< 16) / len2;
          tq = longint'(sx2);
        end
      end
    end
    wx = ux * 65536 - tq * dx;
    wy = uy * 65536 - tq * dy;
    sx2 = wx; w2 = sx2 * sx2;
    sx2 = wy; w2 = w2 + sx2 * sx2;
    lim = ((sw * sw) <<< 30) + (tl <<< 32);
    r.gathered = r.gathered && (w2 <= lim);
    r.hit_time = tq[16:0];
    r.dist_sq = (w2 >= (128'sd1 <<< 95)) ? {63{1'b1}} : w2[94:32];
    r.item_id = p.item_id;
    r.mover_id = p.mover_id;
    return r;
  endfunction

  // Pair word acceptance and result word checking, both at the rising edge.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (pair_if.valid && pair_if.ready) begin
      pair_t p;
      reach_t want;
      p.start_x = pair_if.start_x;   p.start_y = pair_if.start_y;
      p.end_x = pair_if.end_x;       p.end_y = pair_if.end_y;
      p.mover_width = pair_if.mover_width;
      p.item_x = pair_if.item_x;     p.item_y = pair_if.item_y;
      p.item_width = pair_if.item_width;
      p.item_id = pair_if.item_id;   p.mover_id = pair_if.mover_id;
      want = cur_typed ? cur_res : predict_reach(p, tolerance);
      expected_q.insert(expected_q.size(), want);
      pair_taken = 1'b1;
    end
    if (reach_if.valid && reach_if.ready) begin
      results_seen++;
      if (reach_if.gathered) gathers_seen++;
      if (reach_if.degenerate) degens_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycles);
      end else begin
        reach_t e;
        e = expected_q.pop_front();
        if (reach_if.gathered !== e.gathered || reach_if.degenerate !== e.degenerate ||
            reach_if.hit_time !== e.hit_time || reach_if.dist_sq !== e.dist_sq ||
            reach_if.out_item_id !== e.item_id || reach_if.out_mover_id !== e.mover_id) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at cycle %0d, ids %0d/%0d", cycles, e.item_id, e.mover_id);
            $display("  expected g=%0b d=%0b t=%0d sq=%0h ids=%0d/%0d", e.gathered,
                     e.degenerate, e.hit_time, e.dist_sq, e.item_id, e.mover_id);
            $display("  actual   g=%0b d=%0b t=%0d sq=%0h ids=%0d/%0d", reach_if.gathered,
                     reach_if.degenerate, reach_if.hit_time, reach_if.dist_sq,
                     reach_if.out_item_id, reach_if.out_mover_id);
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    reach_if.ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic send_pair(pair_t p, logic typed, reach_t res);
    while ($urandom_range(99) < idle_pct) begin
      pair_if.valid = 1'b0;
      @(negedge clk_i);
    end
    pair_if.start_x = p.start_x;   pair_if.start_y = p.start_y;
    pair_if.end_x = p.end_x;       pair_if.end_y = p.end_y;
    pair_if.mover_width = p.mover_width;
    pair_if.item_x = p.item_x;     pair_if.item_y = p.item_y;
    pair_if.item_width = p.item_width;
    pair_if.item_id = p.item_id;   pair_if.mover_id = p.mover_id;
    cur_typed = typed;
    cur_res = res;
    pair_taken = 1'b0;
    pair_if.valid = 1'b1;
    do @(negedge clk_i); while (!pair_taken);
    pair_if.valid = 1'b0;
  endtask

  task automatic write_tolerance(logic [15:0] value);
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    tolerance = value;
  endtask

  function automatic pair_t make_pair(longint sx, longint sy, longint ex, longint ey,
                                      longint ix, longint iy, longint mw, longint iw);
    pair_t p;
    p.start_x = sx[31:0]; p.start_y = sy[31:0];
    p.end_x = ex[31:0];   p.end_y = ey[31:0];
    p.item_x = ix[31:0];  p.item_y = iy[31:0];
    p.mover_width = mw[31:0];
    p.item_width = iw[31:0];
    p.item_id = $urandom();
    p.mover_id = $urandom();
    return p;
  endfunction

  // Mostly pairs near a segment of moderate length, with some wide-open noise.
  function automatic pair_t random_pair();
    longint sx, sy, dx, dy, ix, iy, f, mw, iw;
    int kind;
    kind = $urandom_range(99);
    if (kind < 10) begin
      return make_pair($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom());
    end
    sx = longint'($urandom_range(1 << 24)) - (1 << 23);
    sy = longint'($urandom_range(1 << 24)) - (1 << 23);
    dx = longint'($urandom_range(1 << 21)) - (1 << 20);
    dy = longint'($urandom_range(1 << 21)) - (1 << 20);
    if (kind < 18) begin
      dx = 0;
      dy = 0;
    end else if (kind < 24) begin
      dx = longint'($urandom_range(8)) - 4;
      dy = longint'($urandom_range(8)) - 4;
    end
    f = longint'($urandom_range(80)) - 10;
    mw = $urandom_range(1 << 18);
    iw = $urandom_range(1 << 18);
    ix = sx + (dx * f) / 60 + longint'($urandom_range(1 << 18)) - (1 << 17);
    iy = sy + (dy * f) / 60 + longint'($urandom_range(1 << 18)) - (1 << 17);
    return make_pair(sx, sy, sx + dx, sy + dy, ix, iy, mw, iw);
  endfunction

  vector_t directed[$];

  task automatic add_row(pair_t p, logic typed, logic g, logic d, logic [16:0] t,
                         logic [62:0] sq);
    vector_t v;
    v.pair = p;
    v.typed = typed;
    v.res.gathered = g;      v.res.degenerate = d;
    v.res.hit_time = t;      v.res.dist_sq = sq;
    v.res.item_id = p.item_id;
    v.res.mover_id = p.mover_id;
    directed.insert(directed.size(), v);
  endtask

  initial begin
    pair_t p;
    reach_t none;
    int phase;
    logic [15:0] settings[4];
    none = '{default: '0};
    pair_if.valid = 1'b0;
    pair_if.start_x = '0; pair_if.start_y = '0; pair_if.end_x = '0; pair_if.end_y = '0;
    pair_if.mover_width = '0; pair_if.item_x = '0; pair_if.item_y = '0;
    pair_if.item_width = '0; pair_if.item_id = '0; pair_if.mover_id = '0;
    reach_if.ready = 1'b0;

    // Degenerate segment with the item on the start point, then one unit away.
    add_row(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 1, 0, 0);
    add_row(make_pair(0, 0, 0, 0, One, 0, 0, 0), 1, 0, 1, 0, 63'h1_0000_0000);
    // Unit segment: midpoint, end point, beyond the end, before the start.
    add_row(make_pair(0, 0, One, 0, One / 2, 0, 0, 0), 1, 1, 0, 17'd32768, 0);
    add_row(make_pair(0, 0, One, 0, One, 0, 0, 0), 1, 1, 0, 17'h10000, 0);
    add_row(make_pair(0, 0, One, 0, 2 * One, 0, 0, 0), 1, 0, 0, 17'h10000,
            63'h1_0000_0000);
    add_row(make_pair(0, 0, One, 0, -One, 0, 0, 0), 1, 0, 0, 0, 63'h1_0000_0000);
    // Extremes of coordinates and widths, checked by the predictor.
    add_row(make_pair(-(1 << 31), -(1 << 31), (1 << 31) - 1, (1 << 31) - 1,
                      (1 << 31) - 1, -(1 << 31), 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0, 0, 0, 0, 0);
    add_row(make_pair((1 << 31) - 1, 0, -(1 << 31), 0, 0, (1 << 31) - 1, 0, 0),
            0, 0, 0, 0, 0);
    add_row(make_pair(-(1 << 31), -(1 << 31), -(1 << 31), -(1 << 31),
                      (1 << 31) - 1, (1 << 31) - 1, 32'hFFFF_FFFF, 0), 0, 0, 0, 0, 0);
    add_row(make_pair(0, 0, 1, 0, 0, 1, 1, 1), 0, 0, 0, 0, 0);
    add_row(make_pair(0, 0, One, One, One, 0, One, One), 0, 0, 0, 0, 0);
    add_row(make_pair(5 * One, 5 * One, -3 * One, 2 * One, One, 7 * One, 4 * One, One),
            0, 0, 0, 0, 0);
    p = make_pair(0, 0, One, 0, One / 2, One, 0, 0);
    p.item_id = 16'hFFFF;
    p.mover_id = 16'hFFFF;
    add_row(p, 0, 0, 0, 0, 0);
    p.item_id = 16'h0000;
    p.mover_id = 16'h0000;
    add_row(p, 0, 0, 0, 0, 0);

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_pair(directed[i].pair, directed[i].typed, directed[i].res);
    // Tolerance extremes on the edge cases, with no expected values typed in.
    write_tolerance(16'hFFFF);
    foreach (directed[i]) send_pair(directed[i].pair, 1'b0, none);

    settings[0] = 16'h0000;
    settings[1] = 16'h0001;
    settings[2] = $urandom();
    settings[3] = 16'hFFFF;
    for (phase = 0; phase < 4; phase++) begin
      write_tolerance(settings[phase]);
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      repeat (NumRandom / 4) send_pair(random_pair(), 1'b0, none);
    end

    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    $display("%0d result words checked: %0d gathers, %0d zero-length moves", results_seen,
             gathers_seen, degens_seen);
    $display("tolerance settings 0, 1, random and 65535 under four idling patterns");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/sgt_pkg.sv
sv/sgt_if.sv
sv/sgt_flow.sv
sv/segment_circle_gather_test.sv
sv/sgt_check.sv
sim/testbench.sv
